/* rtl/core/button_gesture_classifier_core_assert.svh */
// Assertion macros shared by the button gesture classifier RTL.
`ifndef BUTTON_GESTURE_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BGC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bgc assertion failed");
`define BGC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bgc assertion failed");
`else
`define BGC_ASSERT(lbl, clk, rst, prop)
`define BGC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/core/bgc_pkg.sv */
// Types, constants and helper functions of the button gesture classifier.
package bgc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESSED  = 3'd1,
    PH_RELEASED = 3'd2,
    PH_IDENTIFY = 3'd3,
    PH_CLICK    = 3'd4,
    PH_DOUBLE   = 3'd5,
    PH_LONG     = 3'd6,
    PH_LONGER   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    G_NONE   = 3'd0,
    G_CLICK  = 3'd1,
    G_DOUBLE = 3'd2,
    G_LONG   = 3'd3,
    G_LONGER = 3'd4
  } gesture_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLICK_MIN     = 3'd0,
    REG_CLICK_MAX     = 3'd1,
    REG_LONG_MIN      = 3'd2,
    REG_LONG_MAX      = 3'd3,
    REG_LONGER_MIN    = 3'd4,
    REG_LONGER_MAX    = 3'd5,
    REG_DOUBLE_WINDOW = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [TimeW-1:0] click_min;
    logic [TimeW-1:0] click_max;
    logic [TimeW-1:0] long_min;
    logic [TimeW-1:0] long_max;
    logic [TimeW-1:0] longer_min;
    logic [TimeW-1:0] longer_max;
    logic [TimeW-1:0] double_window;
  } cfg_t;

  localparam logic [TimeW-1:0] ClickMinRst = 32'd20;
  localparam logic [TimeW-1:0] ClickMaxRst = 32'd500;
  localparam logic [TimeW-1:0] LongMinRst = 32'd1000;
  localparam logic [TimeW-1:0] LongMaxRst = 32'd3000;
  localparam logic [TimeW-1:0] LongerMinRst = 32'd5000;
  localparam logic [TimeW-1:0] LongerMaxRst = 32'd10000;
  localparam logic [TimeW-1:0] DoubleWindowRst = 32'd300;

  function automatic logic in_band(input logic [TimeW-1:0] t,
                                   input logic [TimeW-1:0] lo,
                                   input logic [TimeW-1:0] hi);
    return (t >= lo) && (t <= hi);
  endfunction

endpackage

/* rtl/core/bgc_cfg.sv */
// Configuration register file of the button gesture classifier.
module bgc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bgc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bgc_pkg::TimeW-1:0]     cfg_data,
  output bgc_pkg::cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.click_min     <= bgc_pkg::ClickMinRst;
      cfg.click_max     <= bgc_pkg::ClickMaxRst;
      cfg.long_min      <= bgc_pkg::LongMinRst;
      cfg.long_max      <= bgc_pkg::LongMaxRst;
      cfg.longer_min    <= bgc_pkg::LongerMinRst;
      cfg.longer_max    <= bgc_pkg::LongerMaxRst;
      cfg.double_window <= bgc_pkg::DoubleWindowRst;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bgc_pkg::REG_CLICK_MIN:     cfg.click_min <= cfg_data;
        bgc_pkg::REG_CLICK_MAX:     cfg.click_max <= cfg_data;
        bgc_pkg::REG_LONG_MIN:      cfg.long_min <= cfg_data;
        bgc_pkg::REG_LONG_MAX:      cfg.long_max <= cfg_data;
        bgc_pkg::REG_LONGER_MIN:    cfg.longer_min <= cfg_data;
        bgc_pkg::REG_LONGER_MAX:    cfg.longer_max <= cfg_data;
        bgc_pkg::REG_DOUBLE_WINDOW: cfg.double_window <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/bgc_fsm.sv */
// Gesture state machine with tick counter and hold-time classification.
`include "button_gesture_classifier_core_assert.svh"

module bgc_fsm (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic                      pin_level,
  input  bgc_pkg::cfg_t             cfg,
  output logic [2:0]                gesture,
  output logic                      held
);

  bgc_pkg::phase_t            phase, phase_next;
  logic [bgc_pkg::TimeW-1:0]  tick_now;
  logic [bgc_pkg::TimeW-1:0]  press_start, press_start_next;
  logic [bgc_pkg::TimeW-1:0]  hold_time, hold_time_next;
  logic [bgc_pkg::TimeW-1:0]  last_click_time, last_click_time_next;
  logic [bgc_pkg::TimeW-1:0]  since_click;

  assign since_click = tick_now - last_click_time;

  always_comb begin
    phase_next           = phase;
    press_start_next     = press_start;
    hold_time_next       = hold_time;
    last_click_time_next = last_click_time;
    unique case (phase)
      bgc_pkg::PH_IDLE: begin
        if (pin_level) begin
          press_start_next = tick_now;
          phase_next       = bgc_pkg::PH_PRESSED;
        end
      end
      bgc_pkg::PH_PRESSED: begin
        if (!pin_level) begin
          hold_time_next = tick_now - press_start;
          phase_next     = bgc_pkg::PH_RELEASED;
        end
      end
      bgc_pkg::PH_RELEASED: begin
        priority if (bgc_pkg::in_band(hold_time, cfg.click_min, cfg.click_max)) begin
          phase_next = bgc_pkg::PH_IDENTIFY;
        end else if (bgc_pkg::in_band(hold_time, cfg.long_min, cfg.long_max)) begin
          phase_next = bgc_pkg::PH_LONG;
        end else if (bgc_pkg::in_band(hold_time, cfg.longer_min, cfg.longer_max)) begin
          phase_next = bgc_pkg::PH_LONGER;
        end else begin
          phase_next = bgc_pkg::PH_IDLE;
        end
      end
      bgc_pkg::PH_IDENTIFY: begin
        if (since_click > cfg.double_window) begin
          last_click_time_next = tick_now;
          phase_next           = bgc_pkg::PH_CLICK;
        end else begin
          phase_next = bgc_pkg::PH_DOUBLE;
        end
      end
      default: phase_next = bgc_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    unique case (phase)
      bgc_pkg::PH_CLICK:  gesture = bgc_pkg::G_CLICK;
      bgc_pkg::PH_DOUBLE: gesture = bgc_pkg::G_DOUBLE;
      bgc_pkg::PH_LONG:   gesture = bgc_pkg::G_LONG;
      bgc_pkg::PH_LONGER: gesture = bgc_pkg::G_LONGER;
      default:            gesture = bgc_pkg::G_NONE;
    endcase
    held = (phase_next == bgc_pkg::PH_PRESSED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= bgc_pkg::PH_IDLE;
      tick_now        <= '0;
      press_start     <= '0;
      hold_time       <= '0;
      last_click_time <= '0;
    end else if (step) begin
      phase           <= phase_next;
      tick_now        <= tick_now + 32'd1;
      press_start     <= press_start_next;
      hold_time       <= hold_time_next;
      last_click_time <= last_click_time_next;
    end
  end

  `BGC_ASSERT(a_tick_advances, clk, rst, step |=> tick_now == $past(tick_now) + 32'd1)
  `BGC_ASSERT(a_release_measured, clk, rst,
    step && phase == bgc_pkg::PH_PRESSED && !pin_level
    |=> phase == bgc_pkg::PH_RELEASED && hold_time == $past(tick_now) - $past(press_start))
  `BGC_ASSERT(a_event_returns_idle, clk, rst, step && gesture != bgc_pkg::G_NONE |=> phase == bgc_pkg::PH_IDLE)

endmodule

/* rtl/core/button_gesture_classifier_core.sv */
// Top level of the button gesture classifier: config, state machine, result register.
// The result of a beat is registered and presented in the cycle after it is accepted.
// Throughput: one beat per cycle unless the output stalls; the state machine advances once per accepted beat.
// Input is taken whenever the result register is empty or is being drained.
// Reset (rst, synchronous) returns to idle, zeroes the tick counter and all
// recorded times, loads the default bands, and empties the result register.
`include "button_gesture_classifier_core_assert.svh"

module button_gesture_classifier_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          pin_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    gesture,
  output logic                          held,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bgc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bgc_pkg::TimeW-1:0]     cfg_data
);

  bgc_pkg::cfg_t  cfg;
  logic           step;
  logic [2:0]     gesture_next;
  logic           held_next;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  bgc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bgc_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pin_level (pin_level),
    .cfg       (cfg),
    .gesture   (gesture_next),
    .held      (held_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      gesture <= gesture_next;
      held    <= held_next;
    end
  end

  `BGC_ASSERT(a_accept_gives_result, clk, rst, in_valid && in_ready |=> out_valid)
  `BGC_ASSERT(a_full_blocks_input, clk, rst, out_valid && !out_ready |-> !in_ready)
  `BGC_ASSERT(a_gesture_code_range, clk, rst, out_valid |-> gesture <= bgc_pkg::G_LONGER)

endmodule

/* tb/button_gesture_classifier_core_tb.sv */
// Self-checking testbench for button_gesture_classifier_core with a built-in gesture predictor.
module button_gesture_classifier_core_tb;

  localparam logic [bgc_pkg::CfgIdxW-1:0] RegSpare = 3'd7;
  localparam int LongHold = 64;

  typedef struct {
    bgc_pkg::gesture_t kind;
    logic              held;
  } gesture_due_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          pin_level = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [2:0]                    gesture;
  logic                          held;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [bgc_pkg::CfgIdxW-1:0]   cfg_index = '0;
  logic [bgc_pkg::TimeW-1:0]     cfg_data = '0;

  bgc_pkg::phase_t               ph;
  logic [bgc_pkg::TimeW-1:0]     tick_cnt;
  logic [bgc_pkg::TimeW-1:0]     press_at;
  logic [bgc_pkg::TimeW-1:0]     hold_len;
  logic [bgc_pkg::TimeW-1:0]     last_click_at;
  bgc_pkg::cfg_t                 bands;

  bit                pin_plan[$];
  gesture_due_t      gestures_due[$];
  gesture_due_t      due;
  int                planned = 0;
  int                taken = 0;
  int                checked = 0;
  int                errors = 0;
  int                kind_count[8];
  logic              in_fire = 1'b0;
  int                send_gap = 0;
  int                send_calm = 0;
  int                recv_hold = 0;
  int                recv_calm = 0;
  int                recv_pick;
  int                stall_asked = 0;
  int                stall_served = 0;

  button_gesture_classifier_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pin_level (pin_level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gesture   (gesture),
    .held      (held),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 80);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_predictor();
    ph = bgc_pkg::PH_IDLE;
    tick_cnt = '0;
    press_at = '0;
    hold_len = '0;
    last_click_at = '0;
    bands = '{bgc_pkg::ClickMinRst, bgc_pkg::ClickMaxRst,
              bgc_pkg::LongMinRst, bgc_pkg::LongMaxRst,
              bgc_pkg::LongerMinRst, bgc_pkg::LongerMaxRst,
              bgc_pkg::DoubleWindowRst};
  endtask

  task automatic classify_tick(input logic pin);
    bgc_pkg::gesture_t g;
    logic [bgc_pkg::TimeW-1:0] since_click;
    g = bgc_pkg::G_NONE;
    since_click = tick_cnt - last_click_at;
    unique case (ph)
      bgc_pkg::PH_IDLE: begin
        if (pin) begin
          press_at = tick_cnt;
          ph = bgc_pkg::PH_PRESSED;
        end
      end
      bgc_pkg::PH_PRESSED: begin
        if (!pin) begin
          hold_len = tick_cnt - press_at;
          ph = bgc_pkg::PH_RELEASED;
        end
      end
      bgc_pkg::PH_RELEASED: begin
        if (hold_len >= bands.click_min && hold_len <= bands.click_max) begin
          ph = bgc_pkg::PH_IDENTIFY;
        end else if (hold_len >= bands.long_min && hold_len <= bands.long_max) begin
          ph = bgc_pkg::PH_LONG;
        end else if (hold_len >= bands.longer_min && hold_len <= bands.longer_max) begin
          ph = bgc_pkg::PH_LONGER;
        end else begin
          ph = bgc_pkg::PH_IDLE;
        end
      end
      bgc_pkg::PH_IDENTIFY: begin
        if (since_click > bands.double_window) begin
          last_click_at = tick_cnt;
          ph = bgc_pkg::PH_CLICK;
        end else begin
          ph = bgc_pkg::PH_DOUBLE;
        end
      end
      bgc_pkg::PH_CLICK: begin
        g = bgc_pkg::G_CLICK;
        ph = bgc_pkg::PH_IDLE;
      end
      bgc_pkg::PH_DOUBLE: begin
        g = bgc_pkg::G_DOUBLE;
        ph = bgc_pkg::PH_IDLE;
      end
      bgc_pkg::PH_LONG: begin
        g = bgc_pkg::G_LONG;
        ph = bgc_pkg::PH_IDLE;
      end
      default: begin
        g = bgc_pkg::G_LONGER;
        ph = bgc_pkg::PH_IDLE;
      end
    endcase
    tick_cnt = tick_cnt + 32'd1;
    gestures_due.push_back('{g, ph == bgc_pkg::PH_PRESSED});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_predictor();
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        classify_tick(pin_level);
        taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      checked++;
      if (!$isunknown(gesture)) kind_count[gesture]++;
      if (gestures_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
      end else begin
        due = gestures_due.pop_front();
        if (gesture !== due.kind)
          report_mismatch($sformatf("result %0d gesture %0d, expected %0d",
                                    checked, gesture, due.kind));
        if (held !== due.held)
          report_mismatch($sformatf("result %0d held %0b, expected %0b",
                                    checked, held, due.held));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pin_plan.size() > 0) begin
        in_valid <= 1'b1;
        pin_level <= pin_plan.pop_front();
        send_gap <= draw_gap(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_asked != stall_served) begin
      stall_served <= stall_served + 1;
      recv_hold <= LongHold;
      out_ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= 1'b0;
    end else begin
      recv_pick = draw_gap(recv_calm);
      if (recv_pick == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        recv_hold <= recv_pick - 1;
      end
    end
  end

  task automatic plan_tick(input bit p);
    pin_plan.push_back(p);
    planned++;
  endtask

  task automatic plan_gestures(input int upto);
    int hold;
    int kind;
    while (planned < upto) begin
      kind = $urandom_range(0, 9);
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 40) : $urandom_range(1, 17);
      if (kind < 7) begin
        repeat (hold) plan_tick(1'b1);
        repeat ($urandom_range(1, 8)) plan_tick(1'b0);
      end else if (kind == 7) begin
        repeat ($urandom_range(3, 15)) plan_tick(1'($urandom_range(0, 1)));
      end else begin
        repeat (hold) plan_tick(1'b1);
        plan_tick(1'b0);
        repeat ($urandom_range(1, 4)) plan_tick(1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic wait_drain();
    do @(negedge clk); while (taken != planned || gestures_due.size() != 0);
  endtask

  task automatic write_reg(input logic [bgc_pkg::CfgIdxW-1:0] idx,
                           input logic [bgc_pkg::TimeW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    unique case (idx)
      bgc_pkg::REG_CLICK_MIN:     bands.click_min = val;
      bgc_pkg::REG_CLICK_MAX:     bands.click_max = val;
      bgc_pkg::REG_LONG_MIN:      bands.long_min = val;
      bgc_pkg::REG_LONG_MAX:      bands.long_max = val;
      bgc_pkg::REG_LONGER_MIN:    bands.longer_min = val;
      bgc_pkg::REG_LONGER_MAX:    bands.longer_max = val;
      bgc_pkg::REG_DOUBLE_WINDOW: bands.double_window = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_bands(input logic [bgc_pkg::TimeW-1:0] c_lo,
                            input logic [bgc_pkg::TimeW-1:0] c_hi,
                            input logic [bgc_pkg::TimeW-1:0] l_lo,
                            input logic [bgc_pkg::TimeW-1:0] l_hi,
                            input logic [bgc_pkg::TimeW-1:0] x_lo,
                            input logic [bgc_pkg::TimeW-1:0] x_hi,
                            input logic [bgc_pkg::TimeW-1:0] win);
    write_reg(bgc_pkg::REG_CLICK_MIN, c_lo);
    write_reg(bgc_pkg::REG_CLICK_MAX, c_hi);
    write_reg(bgc_pkg::REG_LONG_MIN, l_lo);
    write_reg(bgc_pkg::REG_LONG_MAX, l_hi);
    write_reg(bgc_pkg::REG_LONGER_MIN, x_lo);
    write_reg(bgc_pkg::REG_LONGER_MAX, x_hi);
    write_reg(bgc_pkg::REG_DOUBLE_WINDOW, win);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // A minimum-length click right after reset lands inside the double-click window of tick 0.
    plan_tick(1'b0);
    repeat (20) plan_tick(1'b1);
    repeat (4) plan_tick(1'b0);
    wait_drain();

    load_bands(32'd2, 32'd5, 32'd7, 32'd10, 32'd12, 32'd15, 32'd12);
    plan_gestures(175);
    @(posedge clk);
    stall_asked++;
    wait_drain();
    plan_gestures(325);
    wait_drain();

    load_bands(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
    plan_gestures(425);
    wait_drain();

    load_bands(32'd9, 32'd3, 32'd1, 32'd6, 32'd7, 32'd12, 32'hFFFF_FFFF);
    plan_gestures(545);
    @(posedge clk);
    stall_asked++;
    wait_drain();

    for (int n = 0; n < 5; n++) begin
      load_bands($urandom_range(0, 18), $urandom_range(0, 18), $urandom_range(0, 18),
                 $urandom_range(0, 18), $urandom_range(0, 18), $urandom_range(0, 18),
                 $urandom_range(0, 30));
      if (n == 2) write_reg(RegSpare, $urandom());
      plan_gestures(645 + 100 * n);
      wait_drain();
    end

    repeat (8) @(posedge clk);
    $display("summary: %0d ticks classified over 9 band settings, %0d results checked",
             taken, checked);
    $display("summary: none %0d, click %0d, double %0d, long %0d, long-long %0d",
             kind_count[bgc_pkg::G_NONE], kind_count[bgc_pkg::G_CLICK],
             kind_count[bgc_pkg::G_DOUBLE], kind_count[bgc_pkg::G_LONG],
             kind_count[bgc_pkg::G_LONGER]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/bgc_pkg.sv
rtl/core/bgc_cfg.sv
rtl/core/bgc_fsm.sv
rtl/core/button_gesture_classifier_core.sv
tb/button_gesture_classifier_core_tb.sv
